// ===== hdl/lrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_pkg
// Shared types, constants and helpers for the longest-prefix route table.
// ----------------------------------------------------------------------------
package lrt_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int ADDR_W  = 32;
   localparam int LEN_W   = 6;
   localparam int PORT_W  = 8;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   // request actions
   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_LOOKUP = 2'd1,
      ACT_DELETE = 2'd2
   } action_type;

   // response status codes
   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_NOTFOUND = 2'd1,
      STS_DUP      = 2'd2,
      STS_FULL     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // one table slot as read from the store
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] prefix;
      logic [LEN_W-1:0]  len;
      logic [PORT_W-1:0] port;
      logic [ADDR_W-1:0] hop;
   } slot_type;

   // write command to the store
   typedef struct packed {
      logic              ins_en;
      logic              del_en;
      logic [IDX_W-1:0]  idx;
      logic [ADDR_W-1:0] prefix;
      logic [LEN_W-1:0]  len;
      logic [PORT_W-1:0] port;
      logic [ADDR_W-1:0] hop;
   } wr_type;

   // prefix mask for a length of 0..32; length 0 gives an empty mask
   function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
      logic [ADDR_W-1:0] ones;
      ones = '1;
      return ~(ones >> len);
   endfunction

endpackage

// ===== hdl/lrt_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_store
// Route slot storage: per-slot valid flops plus field memories with one
// write port and one registered read port.
// ----------------------------------------------------------------------------
module lrt_store
   import lrt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] rd_idx,
   input  wr_type           wr,
   output slot_type         rd_data
);

   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;
   logic [ADDR_W-1:0]  prefix_mem [ENTRIES];
   logic [LEN_W-1:0]   len_mem    [ENTRIES];
   logic [PORT_W-1:0]  port_mem   [ENTRIES];
   logic [ADDR_W-1:0]  hop_mem    [ENTRIES];
   slot_type           rd_ff;

   // set on insert, drop on delete
   always_comb begin
      valid_in = valid_ff;
      if (wr.ins_en) begin
         valid_in[wr.idx] = 1'b1;
      end
      if (wr.del_en) begin
         valid_in[wr.idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // write fields on insert
   always_ff @(posedge clock) begin
      if (wr.ins_en) begin
         prefix_mem[wr.idx] <= wr.prefix;
         len_mem[wr.idx]    <= wr.len;
         port_mem[wr.idx]   <= wr.port;
         hop_mem[wr.idx]    <= wr.hop;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_ff.valid  <= valid_ff[rd_idx];
      rd_ff.prefix <= prefix_mem[rd_idx];
      rd_ff.len    <= len_mem[rd_idx];
      rd_ff.port   <= port_mem[rd_idx];
      rd_ff.hop    <= hop_mem[rd_idx];
   end

   assign rd_data = rd_ff;

endmodule

// ===== hdl/lrt_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_match
// Shared prefix compare unit: masks and compares one slot against the key,
// either as an exact route match or as an address cover test.
// ----------------------------------------------------------------------------
module lrt_match
   import lrt_pkg::*;
(
   input  logic              exact_mode,
   input  logic [ADDR_W-1:0] key_addr,
   input  logic [LEN_W-1:0]  key_len,
   input  slot_type          slot,
   output logic              hit
);

   logic [LEN_W-1:0]  mask_len;
   logic [ADDR_W-1:0] mask;
   logic              bits_eq;
   logic              len_ok;

   // exact match masks by the key length, cover test by the slot length
   always_comb begin
      mask_len = exact_mode ? key_len : slot.len;
      mask     = len_mask(mask_len);
      bits_eq  = ((key_addr ^ slot.prefix) & mask) == '0;
      len_ok   = !exact_mode || (slot.len == key_len);
      hit      = slot.valid && bits_eq && len_ok;
   end

endmodule

// ===== hdl/longest_prefix_route_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_prefix_route_table
// IPv4 route table with insert, longest-prefix lookup and delete, walking
// every slot through one shared compare unit.
//
//   channel   direction  ports
//   req_      in         req_valid/req_ready, action, address, prefix_len,
//                        port_in, hop_in
//   rsp_      out        rsp_valid/rsp_ready, status, port_out, hop_out,
//                        matched_len
//
// Each request walks the table before a response is loaded: the scan reads
// one slot per cycle from the store, whose read is registered, and a finish
// step then commits. req_ready is high only while idle. A stalled response
// holds the finish step until the output register frees. Synchronous reset
// empties the table at once; no clearing pass.
// ----------------------------------------------------------------------------
module longest_prefix_route_table
   import lrt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_action,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [LEN_W-1:0]  req_prefix_len,
   input  logic [PORT_W-1:0] req_port_in,
   input  logic [ADDR_W-1:0] req_hop_in,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [PORT_W-1:0] rsp_port_out,
   output logic [ADDR_W-1:0] rsp_hop_out,
   output logic [LEN_W-1:0]  rsp_matched_len
);

   state_type         state_ff, state_in;
   // request registers
   logic [1:0]        act_ff, act_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [PORT_W-1:0] port_ff, port_in;
   logic [ADDR_W-1:0] hop_ff, hop_in;
   // scan control
   logic [IDX_W-1:0]  issue_idx_ff, issue_idx_in;
   logic              issue_on_ff, issue_on_in;
   logic [IDX_W-1:0]  eval_idx_ff, eval_idx_in;
   logic              eval_on_ff, eval_on_in;
   logic              eval_last_ff, eval_last_in;
   // search results
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [LEN_W-1:0]  best_len_ff, best_len_in;
   logic [PORT_W-1:0] best_port_ff, best_port_in;
   logic [ADDR_W-1:0] best_hop_ff, best_hop_in;
   logic              free_found_ff, free_found_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [PORT_W-1:0] rsp_port_ff, rsp_port_in;
   logic [ADDR_W-1:0] rsp_hop_ff, rsp_hop_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;

   logic              accept;
   logic              out_free;
   logic              exact_mode;
   logic              hit;
   logic              take;
   slot_type          slot;
   wr_type            wr;

   lrt_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (issue_idx_ff),
      .wr      (wr),
      .rd_data (slot)
   );

   lrt_match u_match (
      .exact_mode (exact_mode),
      .key_addr   (addr_ff),
      .key_len    (len_ff),
      .slot       (slot),
      .hit        (hit)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign exact_mode = (act_ff != ACT_LOOKUP);

   // lookup keeps the strictly longer cover; insert and delete keep the first
   assign take = hit && (!found_ff || (!exact_mode && (slot.len > best_len_ff)));

   // sequencer: next state, scan bookkeeping, commit and response load
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      addr_in       = addr_ff;
      len_in        = len_ff;
      port_in       = port_ff;
      hop_in        = hop_ff;
      issue_idx_in  = issue_idx_ff;
      issue_on_in   = issue_on_ff;
      eval_on_in    = issue_on_ff;
      eval_idx_in   = issue_idx_ff;
      eval_last_in  = (issue_idx_ff == LAST_IDX);
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_len_in   = best_len_ff;
      best_port_in  = best_port_ff;
      best_hop_in   = best_hop_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_port_in   = rsp_port_ff;
      rsp_hop_in    = rsp_hop_ff;
      rsp_len_in    = rsp_len_ff;
      wr            = '0;
      wr.prefix     = addr_ff;
      wr.len        = len_ff;
      wr.port       = port_ff;
      wr.hop        = hop_ff;
      wr.idx        = (act_ff == ACT_INSERT) ? free_idx_ff : best_idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_in        = req_action;
               addr_in       = req_address;
               len_in        = (req_prefix_len > MAX_LEN) ? MAX_LEN : req_prefix_len;
               port_in       = req_port_in;
               hop_in        = req_hop_in;
               issue_idx_in  = '0;
               issue_on_in   = 1'b1;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // advance the read pointer until the last slot is issued
            if (issue_on_ff) begin
               if (issue_idx_ff == LAST_IDX) begin
                  issue_on_in = 1'b0;
               end else begin
                  issue_idx_in = issue_idx_ff + 1'b1;
               end
            end
            // evaluate the slot read last cycle
            if (eval_on_ff) begin
               if (take) begin
                  found_in     = 1'b1;
                  best_idx_in  = eval_idx_ff;
                  best_len_in  = slot.len;
                  best_port_in = slot.port;
                  best_hop_in  = slot.hop;
               end
               if (!slot.valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = eval_idx_ff;
               end
               if (eval_last_ff) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            // commit the table change and load the response once it is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STS_NOTFOUND;
               rsp_port_in   = '0;
               rsp_hop_in    = '0;
               rsp_len_in    = '0;
               case (act_ff)
                  ACT_INSERT: begin
                     if (found_ff) begin
                        rsp_status_in = STS_DUP;
                     end else if (free_found_ff) begin
                        wr.ins_en     = 1'b1;
                        rsp_status_in = STS_OK;
                     end else begin
                        rsp_status_in = STS_FULL;
                     end
                  end
                  ACT_LOOKUP: begin
                     if (found_ff) begin
                        rsp_status_in = STS_OK;
                        rsp_port_in   = best_port_ff;
                        rsp_hop_in    = best_hop_ff;
                        rsp_len_in    = best_len_ff;
                     end
                  end
                  ACT_DELETE: begin
                     if (found_ff) begin
                        wr.del_en     = 1'b1;
                        rsp_status_in = STS_OK;
                     end
                  end
                  default: begin
                     rsp_status_in = STS_NOTFOUND;
                  end
               endcase
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_on_ff   <= 1'b0;
         eval_on_ff    <= 1'b0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_on_ff   <= issue_on_in;
         eval_on_ff    <= eval_on_in;
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      addr_ff       <= addr_in;
      len_ff        <= len_in;
      port_ff       <= port_in;
      hop_ff        <= hop_in;
      issue_idx_ff  <= issue_idx_in;
      eval_idx_ff   <= eval_idx_in;
      eval_last_ff  <= eval_last_in;
      best_idx_ff   <= best_idx_in;
      best_len_ff   <= best_len_in;
      best_port_ff  <= best_port_in;
      best_hop_ff   <= best_hop_in;
      free_idx_ff   <= free_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_port_ff   <= rsp_port_in;
      rsp_hop_ff    <= rsp_hop_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_port_out    = rsp_port_ff;
   assign rsp_hop_out     = rsp_hop_ff;
   assign rsp_matched_len = rsp_len_ff;

endmodule

// ===== hdl/lrt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_checker
// Port-level checks for the route table, bound to the top level.
// ----------------------------------------------------------------------------
module lrt_checker
   import lrt_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [1:0]        req_action,
   input logic [ADDR_W-1:0] req_address,
   input logic [LEN_W-1:0]  req_prefix_len,
   input logic [PORT_W-1:0] req_port_in,
   input logic [ADDR_W-1:0] req_hop_in,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [1:0]        rsp_status,
   input logic [PORT_W-1:0] rsp_port_out,
   input logic [ADDR_W-1:0] rsp_hop_out,
   input logic [LEN_W-1:0]  rsp_matched_len
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_hop_out) && $stable(rsp_port_out) && $stable(rsp_matched_len))
      else $error("response changed while stalled");

   // one request at a time: busy right after acceptance
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a scan is running");

   // route fields are zero on any response whose status is not OK
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STS_OK) |->
         rsp_port_out == '0 && rsp_hop_out == '0 && rsp_matched_len == '0)
      else $error("route fields set on a failed response");

   // matched length never exceeds the address width
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_matched_len <= MAX_LEN)
      else $error("matched length out of range");

endmodule

bind longest_prefix_route_table lrt_checker u_lrt_checker (.*);
